FILE: sv/half_max_peak_region_finder_macros.svh
// Assertion macros for the half-maximum peak region finder checker.
`ifndef HALF_MAX_PEAK_REGION_FINDER_MACROS_SVH
`define HALF_MAX_PEAK_REGION_FINDER_MACROS_SVH

// Property checked at every clock, off while reset is held.
`define HMPRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define HMPRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/hmprf_pkg.sv
// Shared constants and controller/datapath interface types for the peak region finder.
`default_nettype none
package hmprf_pkg;

  localparam int BUF_DEPTH   = 1024;
  localparam int ADDR_W      = $clog2(BUF_DEPTH);
  localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
  localparam int IDX_W       = $clog2(BUF_DEPTH + 2);
  localparam int SAMPLE_W    = 16;
  localparam int AMP_W       = SAMPLE_W - 1;
  localparam int SUM_W       = SAMPLE_W + ADDR_W;
  localparam int MAX_REGIONS = 64;
  localparam int RCNT_W      = $clog2(MAX_REGIONS + 2);
  localparam int GAP_W       = 8;
  localparam int WTH_W       = 11;
  localparam int CFG_W       = 11;
  localparam int DCNT_W      = $clog2(SUM_W);

  localparam logic CFG_GAP = 1'b0;
  localparam logic CFG_WTH = 1'b1;

  localparam logic [GAP_W-1:0] GAP_RST = GAP_W'(10);
  localparam logic [WTH_W-1:0] WTH_RST = WTH_W'(5);

  typedef struct packed {
    logic load;
    logic clear;
    logic div_init;
    logic div_step;
    logic pass_init;
    logic pass1_init;
    logic seek_step;
    logic run_step;
    logic judge;
    logic peak_step;
    logic emit_load;
    logic emit_null;
    logic emit_ack;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic lvl_pos;
    logic gap_zero;
    logic run_hit;
    logic wide;
    logic pass1;
    logic total_zero;
    logic peak_end;
    logic div_last;
    logic out_done;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: sv/hmprf_dp.sv
// Datapath: sample memory, statistics, divider, scan registers and result register.
`default_nettype none
module hmprf_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hmprf_pkg::dp_cmd_t            cmd,
  output hmprf_pkg::dp_stat_t                stat,
  input  wire logic signed [hmprf_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [hmprf_pkg::CFG_W-1:0]   cfg_data,
  output logic [hmprf_pkg::CNT_W-1:0]        out_region_start,
  output logic [hmprf_pkg::CNT_W-1:0]        out_region_end,
  output logic [hmprf_pkg::ADDR_W-1:0]       out_peak_index,
  output logic [hmprf_pkg::AMP_W-1:0]        out_peak_amplitude,
  output logic signed [hmprf_pkg::SAMPLE_W-1:0] out_baseline,
  output logic                               out_valid_res,
  output logic                               out_overflow,
  output logic                               out_done_res
);
  import hmprf_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [BUF_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic [ADDR_W-1:0]          rd_addr;

  logic [CNT_W-1:0]        cnt_r;
  logic [AMP_W-1:0]        max_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [GAP_W-1:0]        gap_r;
  logic [WTH_W-1:0]        wth_r;

  logic [CNT_W-1:0]  rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic              neg_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic signed [SAMPLE_W-1:0] base_r;

  logic              pass_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] fs_r;
  logic [CNT_W-1:0]  ff_r;
  logic [GAP_W-1:0]  z_r;
  logic [CNT_W-1:0]  ws_r, we_r;
  logic [AMP_W-1:0]  pk_r;
  logic [ADDR_W-1:0] loc_r;
  logic [RCNT_W-1:0] total_r, emitted_r;

  logic              full;
  logic              gt;
  logic [AMP_W-1:0]  lvl;
  logic              idx_end;
  logic              run_hit;
  logic [GAP_W:0]    z_inc;
  logic [GAP_W:0]    d2;
  logic [CNT_W-1:0]  width;
  logic              wide;
  logic [CNT_W-1:0]  ws;
  logic [CNT_W:0]    we_sum;
  logic [CNT_W-1:0]  we;
  logic [CNT_W:0]    div_sh;
  logic              div_ge;
  logic [SAMPLE_W-1:0] q16;
  logic [RCNT_W-1:0] lim;
  logic              final_res;
  logic              ovf;

  assign full    = (cnt_r == CNT_W'(BUF_DEPTH));
  assign gt      = $signed({rdata_r, 1'b0}) > $signed({2'b00, max_r});
  assign lvl     = gt ? rdata_r[AMP_W-1:0] : '0;
  assign idx_end = (idx_r >= IDX_W'(cnt_r));
  assign z_inc   = {1'b0, z_r} + (GAP_W+1)'(1);
  assign run_hit = !gt && (z_inc == {1'b0, gap_r});
  assign d2      = {gap_r, 1'b0};
  assign width   = ff_r - CNT_W'(fs_r);
  assign wide    = (width > CNT_W'(wth_r));
  assign ws      = (CNT_W'(fs_r) >= CNT_W'(d2)) ? CNT_W'(fs_r) - CNT_W'(d2) : '0;
  assign we_sum  = {1'b0, ff_r} + (CNT_W+1)'(d2);
  assign we      = (we_sum > {1'b0, cnt_r}) ? cnt_r : we_sum[CNT_W-1:0];
  assign div_sh  = {rem_r, quo_r[SUM_W-1]};
  assign div_ge  = (div_sh >= {1'b0, cnt_r});
  assign q16     = quo_r[SAMPLE_W-1:0];
  assign lim     = (total_r > RCNT_W'(MAX_REGIONS)) ? RCNT_W'(MAX_REGIONS) : total_r;
  assign final_res = ((emitted_r + RCNT_W'(1)) == lim);
  assign ovf     = (total_r > RCNT_W'(MAX_REGIONS));

  always_comb begin
    stat.idx_end    = idx_end;
    stat.lvl_pos    = gt;
    stat.gap_zero   = (gap_r == '0);
    stat.run_hit    = run_hit;
    stat.wide       = wide;
    stat.pass1      = pass_r;
    stat.total_zero = (total_r == '0);
    stat.peak_end   = (idx_r >= IDX_W'(we_r));
    stat.div_last   = (dcnt_r == DCNT_W'(SUM_W - 1));
    stat.out_done   = out_done_res;
  end

  // scan index; the memory reads at the next index so data lines up with idx_r
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.pass_init || cmd.pass1_init) begin
      idx_nxt = '0;
    end else if (cmd.seek_step || cmd.peak_step) begin
      idx_nxt = idx_r + IDX_W'(1);
    end else if (cmd.run_step && !idx_end && !run_hit) begin
      idx_nxt = idx_r + IDX_W'(1);
    end else if (cmd.judge) begin
      if (!wide) begin
        idx_nxt = IDX_W'(ff_r) + IDX_W'(1);
      end else if (!pass_r) begin
        idx_nxt = IDX_W'(we) + IDX_W'(1);
      end else begin
        idx_nxt = IDX_W'(ws);
      end
    end else if (cmd.emit_ack) begin
      idx_nxt = IDX_W'(we_r) + IDX_W'(1);
    end
  end
  assign rd_addr = idx_nxt[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[cnt_r[ADDR_W-1:0]] <= in_sample;
    end
    rdata_r <= mem[rd_addr];
  end

  // buffer statistics and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      max_r <= '0;
      sum_r <= '0;
      gap_r <= GAP_RST;
      wth_r <= WTH_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GAP: gap_r <= cfg_data[GAP_W-1:0];
          CFG_WTH: wth_r <= cfg_data[WTH_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        cnt_r <= '0;
        max_r <= '0;
        sum_r <= '0;
      end else if (cmd.load && !full) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (in_sample > $signed({1'b0, max_r})) begin
          max_r <= in_sample[AMP_W-1:0];
        end
        sum_r <= sum_r + {{(SUM_W-SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample};
      end
    end
  end

  // restoring divider on the magnitude of the sum
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= '0;
      quo_r  <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
      neg_r  <= sum_r[SUM_W-1];
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= div_ge ? CNT_W'(div_sh - {1'b0, cnt_r}) : div_sh[CNT_W-1:0];
      quo_r  <= {quo_r[SUM_W-2:0], div_ge};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r    <= 1'b0;
      total_r   <= '0;
      emitted_r <= '0;
    end else begin
      if (cmd.pass_init) begin
        pass_r    <= 1'b0;
        total_r   <= '0;
        emitted_r <= '0;
      end else if (cmd.pass1_init) begin
        pass_r <= 1'b1;
      end else if (cmd.judge && wide && !pass_r && (total_r <= RCNT_W'(MAX_REGIONS))) begin
        total_r <= total_r + RCNT_W'(1);
      end else if (cmd.emit_ack) begin
        emitted_r <= emitted_r + RCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.pass_init) begin
      if (cnt_r == '0) begin
        base_r <= '0;
      end else begin
        base_r <= neg_r ? -$signed(q16) : $signed(q16);
      end
    end
    if (cmd.seek_step && gt) begin
      fs_r <= idx_r[ADDR_W-1:0];
      z_r  <= '0;
      ff_r <= CNT_W'(idx_r) + CNT_W'(1);
    end
    if (cmd.run_step) begin
      if (idx_end) begin
        ff_r <= cnt_r - CNT_W'(z_r);
      end else if (run_hit) begin
        ff_r <= CNT_W'(idx_r) - CNT_W'(gap_r) + CNT_W'(1);
      end else if (gt) begin
        z_r <= '0;
      end else begin
        z_r <= z_inc[GAP_W-1:0];
      end
    end
    if (cmd.judge) begin
      ws_r  <= ws;
      we_r  <= we;
      pk_r  <= '0;
      loc_r <= '0;
    end
    if (cmd.peak_step && (lvl >= pk_r)) begin
      pk_r  <= lvl;
      loc_r <= idx_r[ADDR_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_region_start   <= ws_r;
      out_region_end     <= we_r;
      out_peak_index     <= loc_r;
      out_peak_amplitude <= pk_r;
      out_baseline       <= base_r;
      out_valid_res      <= 1'b1;
      out_overflow       <= ovf;
      out_done_res       <= final_res;
    end else if (cmd.emit_null) begin
      out_region_start   <= '0;
      out_region_end     <= '0;
      out_peak_index     <= '0;
      out_peak_amplitude <= '0;
      out_baseline       <= base_r;
      out_valid_res      <= 1'b0;
      out_overflow       <= 1'b0;
      out_done_res       <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: sv/hmprf_ctrl.sv
// Controller: load, divide, two scan passes and result handshake sequencing.
`default_nettype none
module hmprf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire hmprf_pkg::dp_stat_t stat,
  output hmprf_pkg::dp_cmd_t      cmd
);
  import hmprf_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_DIVI  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_PINIT = 4'd3;
  localparam logic [3:0] S_SEEK  = 4'd4;
  localparam logic [3:0] S_RUN   = 4'd5;
  localparam logic [3:0] S_JUDGE = 4'd6;
  localparam logic [3:0] S_PEAK  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_PINIT;
        end
      end
      S_PINIT: begin
        cmd.pass_init = 1'b1;
        state_nxt     = S_SEEK;
      end
      S_SEEK: begin
        if (stat.idx_end) begin
          if (stat.pass1) begin
            cmd.clear = 1'b1;
            state_nxt = S_LOAD;
          end else if (stat.total_zero) begin
            cmd.emit_null = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            cmd.pass1_init = 1'b1;
          end
        end else begin
          cmd.seek_step = 1'b1;
          if (stat.lvl_pos) begin
            state_nxt = stat.gap_zero ? S_JUDGE : S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd.run_step = 1'b1;
        if (stat.idx_end || stat.run_hit) begin
          state_nxt = S_JUDGE;
        end
      end
      S_JUDGE: begin
        cmd.judge = 1'b1;
        state_nxt = (stat.wide && stat.pass1) ? S_PEAK : S_SEEK;
      end
      S_PEAK: begin
        if (stat.peak_end) begin
          cmd.emit_load = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          cmd.peak_step = 1'b1;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_ack = 1'b1;
          if (stat.out_done) begin
            cmd.clear = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_SEEK;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/half_max_peak_region_finder.sv
// Top level of the half-maximum peak region finder.
//
//  channel | handshake           | word
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid/in_ready   | in_sample, in_last
//  out     | out_valid/out_ready | region bounds, peak, baseline, flags
//  cfg     | cfg_we (no wait)    | cfg_index, cfg_data
//
// Flow: one sample word per cycle while loading (up to 1024 kept, the rest
// dropped). After the last word the mean is formed in the divider, one
// quotient bit per cycle, then two passes scan the buffer through the single
// memory read port, and on the second pass the indices of each widened region
// are re-read for the peak search. The first pass only counts regions so the
// overflow flag is known on every result.
// Reset: synchronous, active low; clears count, maximum, sum and region
// counters and reloads gap and width; the sample memory is not cleared.
// Stalls: in_ready is low from the last word until the final result word is
// taken; each result waits in the output register while out_ready is low.
`default_nettype none
module half_max_peak_region_finder (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [hmprf_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                                 in_last,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [hmprf_pkg::CNT_W-1:0]               out_region_start,
  output logic [hmprf_pkg::CNT_W-1:0]               out_region_end,
  output logic [hmprf_pkg::ADDR_W-1:0]              out_peak_index,
  output logic [hmprf_pkg::AMP_W-1:0]               out_peak_amplitude,
  output logic signed [hmprf_pkg::SAMPLE_W-1:0]     out_baseline,
  output logic                                      out_valid_res,
  output logic                                      out_overflow,
  output logic                                      out_done_res,
  input  wire logic                                 cfg_we,
  input  wire logic                                 cfg_index,
  input  wire logic [hmprf_pkg::CFG_W-1:0]          cfg_data
);
  import hmprf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing: load, mean, counting pass, reporting pass
  hmprf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // memory, statistics, divider and scan registers
  hmprf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_sample          (in_sample),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_region_start   (out_region_start),
    .out_region_end     (out_region_end),
    .out_peak_index     (out_peak_index),
    .out_peak_amplitude (out_peak_amplitude),
    .out_baseline       (out_baseline),
    .out_valid_res      (out_valid_res),
    .out_overflow       (out_overflow),
    .out_done_res       (out_done_res)
  );

endmodule
`default_nettype wire

FILE: sv/hmprf_checker.sv
// Port-level checker for the peak region finder, bound to the top level.
`default_nettype none
`include "half_max_peak_region_finder_macros.svh"
module hmprf_port_props (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_ready,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_ready,
  input  wire logic [hmprf_pkg::CNT_W-1:0]          out_region_start,
  input  wire logic [hmprf_pkg::CNT_W-1:0]          out_region_end,
  input  wire logic [hmprf_pkg::ADDR_W-1:0]         out_peak_index,
  input  wire logic                                 out_valid_res,
  input  wire logic                                 out_overflow,
  input  wire logic                                 out_done_res
);
  import hmprf_pkg::*;

  `HMPRF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")
  `HMPRF_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken while results pending")
  `HMPRF_ASSERT(a_null_final, (out_valid && !out_valid_res) |-> (out_done_res && !out_overflow), "empty result not final")
  `HMPRF_ASSERT(a_peak_inside, (out_valid && out_valid_res) |-> ((out_region_start <= CNT_W'(out_peak_index)) && (CNT_W'(out_peak_index) < out_region_end)), "peak outside region")

endmodule

bind half_max_peak_region_finder hmprf_port_props u_hmprf_port_props (.*);
`default_nettype wire

FILE: tb/hmprf_checker.sv
// Watches the sample, region and configuration ports, predicts each region word and compares.
`timescale 1ns / 1ps
`default_nettype none
module hmprf_checker (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  input  wire logic                                  in_ready,
  input  wire logic signed [hmprf_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                                  in_last,
  input  wire logic                                  out_valid,
  input  wire logic                                  out_ready,
  input  wire logic [hmprf_pkg::CNT_W-1:0]           out_region_start,
  input  wire logic [hmprf_pkg::CNT_W-1:0]           out_region_end,
  input  wire logic [hmprf_pkg::ADDR_W-1:0]          out_peak_index,
  input  wire logic [hmprf_pkg::AMP_W-1:0]           out_peak_amplitude,
  input  wire logic signed [hmprf_pkg::SAMPLE_W-1:0] out_baseline,
  input  wire logic                                  out_valid_res,
  input  wire logic                                  out_overflow,
  input  wire logic                                  out_done_res,
  input  wire logic                                  cfg_we,
  input  wire logic                                  cfg_index,
  input  wire logic [hmprf_pkg::CFG_W-1:0]           cfg_data,
  output int                                         fail_count,
  output int                                         regions_pending,
  output int                                         regions_seen,
  output int                                         overflow_seen
);
  import hmprf_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0]    rstart;
    logic [CNT_W-1:0]    rend;
    logic [ADDR_W-1:0]   pidx;
    logic [AMP_W-1:0]    pamp;
    logic [SAMPLE_W-1:0] base;
    logic                vres;
    logic                ovf;
    logic                done;
  } region_word_t;

  region_word_t expected_regions[$];

  logic signed [SAMPLE_W-1:0] spectrum[BUF_DEPTH];
  int  above_half[BUF_DEPTH];
  int  fill;
  int  spec_max;
  longint spec_sum;
  int  gap_len;
  int  min_width;

  assign regions_pending = expected_regions.size();

  function automatic bit gap_clear(input int at, input int size);
    for (int j = at; j < at + gap_len && j < size; j++)
      if (above_half[j] > 0) return 0;
    return 1;
  endfunction

  // Threshold at half max, scan for regions, queue one word per region (at most MAX_REGIONS) or one empty word if none.
  task automatic find_regions();
    int size, i, fs, ff, ws, we, pk, loc, total;
    longint mean;
    region_word_t w;
    region_word_t found[$];
    size = fill;
    mean = (size > 0) ? spec_sum / size : 0;
    total = 0;
    for (int k = 0; k < size; k++)
      above_half[k] = (2 * int'(spectrum[k]) > spec_max) ? int'(spectrum[k]) : 0;
    i = 0;
    while (i < size) begin
      if (above_half[i] <= 0) begin
        i++;
        continue;
      end
      fs = i;
      ff = size;
      forever begin
        i++;
        if (i >= size) break;
        if (gap_clear(i, size)) begin
          ff = i;
          break;
        end
      end
      if (ff - fs > min_width) begin
        ws = (fs >= 2 * gap_len) ? fs - 2 * gap_len : 0;
        we = (ff + 2 * gap_len > size) ? size : ff + 2 * gap_len;
        pk = 0;
        loc = 0;
        for (int j = ws; j < we; j++)
          if (above_half[j] >= pk) begin
            pk = above_half[j];
            loc = j;
          end
        if (found.size() < MAX_REGIONS) begin
          w = '0;
          w.rstart = CNT_W'(ws);
          w.rend   = CNT_W'(we);
          w.pidx   = ADDR_W'(loc);
          w.pamp   = AMP_W'(pk);
          w.base   = SAMPLE_W'(mean);
          w.vres   = 1'b1;
          found.push_back(w);
        end
        total++;
        i = we;
      end else begin
        i = ff;
      end
      i++;
    end
    if (found.size() == 0) begin
      w = '0;
      w.base = SAMPLE_W'(mean);
      found.push_back(w);
    end
    foreach (found[k]) begin
      found[k].ovf  = (total > MAX_REGIONS);
      found[k].done = (k == found.size() - 1);
      expected_regions.push_back(found[k]);
    end
    fill = 0;
    spec_max = 0;
    spec_sum = 0;
  endtask

  task automatic compare_word(input region_word_t got);
    region_word_t want;
    if (expected_regions.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected region word %p", $realtime, got);
      return;
    end
    want = expected_regions.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      spec_max = 0;
      spec_sum = 0;
      gap_len = int'(GAP_RST);
      min_width = int'(WTH_RST);
      fail_count = 0;
      regions_seen = 0;
      overflow_seen = 0;
      expected_regions.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GAP) gap_len = int'(cfg_data[GAP_W-1:0]);
        else                      min_width = int'(cfg_data[WTH_W-1:0]);
      end
      if (in_valid && in_ready) begin
        if (fill < BUF_DEPTH) begin
          spectrum[fill] = in_sample;
          fill = fill + 1;
          if (int'(in_sample) > spec_max) spec_max = int'(in_sample);
          spec_sum = spec_sum + in_sample;
        end
        if (in_last) find_regions();
      end
      if (out_valid && out_ready) begin
        regions_seen = regions_seen + 1;
        if (out_overflow) overflow_seen = overflow_seen + 1;
        compare_word({out_region_start, out_region_end, out_peak_index, out_peak_amplitude,
                      out_baseline, out_valid_res, out_overflow, out_done_res});
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/tb.sv
// Top of the peak region finder testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import hmprf_pkg::*;

  localparam int STALL_LIMIT = 200000; // worst single scan is far below this
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off for backpressure

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic in_last;
  logic out_valid;
  logic out_ready;
  logic [CNT_W-1:0] out_region_start;
  logic [CNT_W-1:0] out_region_end;
  logic [ADDR_W-1:0] out_peak_index;
  logic [AMP_W-1:0] out_peak_amplitude;
  logic signed [SAMPLE_W-1:0] out_baseline;
  logic out_valid_res;
  logic out_overflow;
  logic out_done_res;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int fail_count;
  int regions_pending;
  int regions_seen;
  int overflow_seen;

  // idle odds in percent, set per phase by the stimulus
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int buffers_sent;
  int words_sent;

  half_max_peak_region_finder u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample, .in_last,
    .out_valid, .out_ready, .out_region_start, .out_region_end, .out_peak_index,
    .out_peak_amplitude, .out_baseline, .out_valid_res, .out_overflow, .out_done_res,
    .cfg_we, .cfg_index, .cfg_data
  );

  hmprf_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample, .in_last,
    .out_valid, .out_ready, .out_region_start, .out_region_end, .out_peak_index,
    .out_peak_amplitude, .out_baseline, .out_valid_res, .out_overflow, .out_done_res,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .regions_pending, .regions_seen, .overflow_seen
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls; one long hold-off when asked, counted here.
  initial begin
    int held;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        out_ready <= 1'b0;
        held++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: cycles without any accepted word on either channel.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // One sample word; entered and left at a falling edge. Valid stays high
  // into the next word unless the sender idles.
  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input bit l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_last   <= l;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (l) buffers_sent++;
    @(negedge clk);
  endtask

  // Block is idle once every region word is back and the scan has wound down.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (regions_pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Random spectrum: noise floor with one peak and scattered spikes, sometimes raw full-range or all-negative words.
  task automatic random_spectrum();
    int len, shape, centre, height, hw;
    logic signed [SAMPLE_W-1:0] s;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
    shape = $urandom_range(0, 9);
    centre = $urandom_range(0, len - 1);
    height = $urandom_range(1, 32767);
    hw = $urandom_range(0, 4);
    for (int k = 0; k < len; k++) begin
      if (shape == 0) s = SAMPLE_W'($urandom);
      else if (shape == 1) s = -SAMPLE_W'($urandom_range(1, 32768));
      else begin
        s = SAMPLE_W'(int'($urandom_range(0, 100)) - 50);
        if (k >= centre - hw && k <= centre + hw) s = SAMPLE_W'(height);
        else if ($urandom_range(0, 7) == 0) s = SAMPLE_W'($urandom_range(0, height));
      end
      send_word(s, k == len - 1);
    end
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    int gap_pick[4];
    int wth_pick[4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_last = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_GAP;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    buffers_sent = 0;
    words_sent = 0;
    phase_idle  = '{0, 66, 0, 27};
    phase_stall = '{0, 0, 66, 27};
    gap_pick = '{1, 255, 3, 2};
    wth_pick = '{0, 1024, 2, 1};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, at reset register values: extremes, single samples, all negative, a plateau.
    send_word(16'sh7FFF, 1'b0);
    send_word(-16'sh8000, 1'b0);
    send_word(16'sd0, 1'b0);
    send_word(16'sh7FFF, 1'b1);
    send_word(16'sd0, 1'b1);
    send_word(16'sd5, 1'b1);
    send_word(-16'sd7, 1'b0);
    send_word(-16'sd1, 1'b1);
    for (int k = 0; k < 12; k++) send_word((k >= 2 && k <= 9) ? 16'sd1000 : 16'sd3, k == 11);
    drain();

    // Zero gap, no width floor: a spike on every other sample gives one more
    // region than can be reported.
    write_reg(CFG_GAP, 0);
    write_reg(CFG_WTH, 0);
    for (int k = 0; k < 2 * MAX_REGIONS + 1; k++)
      send_word((k % 2 == 0) ? 16'sd100 : 16'sd0, k == 2 * MAX_REGIONS);
    drain();

    // Random phases, each under its own idling and register setting; at least
    // two buffers each so the sender keeps offering while results wait.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      write_reg(CFG_GAP, ($urandom_range(0, 1) == 0) ? gap_pick[p] : $urandom_range(1, 255));
      write_reg(CFG_WTH, (p < 2) ? wth_pick[p] : $urandom_range(0, 6));
      if (p == 2) hold_req = 1'b1;
      for (int b = 0; b < 2 || words_sent < 150 + 6 * (p + 1); b++)
        random_spectrum();
      drain();
    end

    $display("covered %0d buffers, %0d sample words, %0d region words (%0d with overflow)",
             buffers_sent, words_sent, regions_seen, overflow_seen);
    $display("zero-gap region overflow plus random gap and width settings, four idling mixes");
    if (fail_count == 0 && regions_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
